FILE: rtl/core/gcme_pkg.sv
// ----------------------------------------------------------------------------
// gcme_pkg
// Shared widths, status codes and controller/datapath handshake types for the
// glyph cache with minimum-code eviction.
// ----------------------------------------------------------------------------
package gcme_pkg;

   localparam int CODE_W   = 16;
   localparam int GB_W     = 10;
   localparam int OFF_W    = 23;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 3;
   localparam int BYTE_W   = 8;
   localparam int LIN_W    = 14;   // glyph index 0..8835

   localparam logic [BYTE_W-1:0] BYTE_LO  = 8'hA1;
   localparam logic [BYTE_W-1:0] BYTE_HI  = 8'hFE;
   localparam logic [7:0]        ROW_SPAN = 8'd94;
   localparam logic [GB_W-1:0]   GB_RESET = 10'd32;

   localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERT   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EVICT    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_KEPT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd4;

   typedef struct packed {
      logic load;     // capture the accepted word, clear scan state
      logic scan;     // step the tag scan
      logic finish;   // decide, update the cache, load the result register
   } gcme_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } gcme_sts_type;

endpackage

FILE: rtl/core/gcme_ctrl.sv
// ----------------------------------------------------------------------------
// gcme_ctrl
// Sequencer: accepts one word, runs the tag scan, then hands the result to the
// output register once it is free.
// ----------------------------------------------------------------------------
module gcme_ctrl import gcme_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  gcme_sts_type sts,
   output gcme_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/gcme_dp.sv
// ----------------------------------------------------------------------------
// gcme_dp
// Datapath: code store, serial match/minimum scan, offset multiplier, fill
// count, glyph size register and the result register.
// ----------------------------------------------------------------------------
module gcme_dp import gcme_pkg::*; #(
   parameter int CACHE_ENTRIES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  gcme_cmd_type        cmd,
   output gcme_sts_type        sts,
   input  logic [CODE_W-1:0]   req_char_code,
   input  logic                csr_wr_en,
   input  logic [GB_W-1:0]     csr_wr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [OFF_W-1:0]    rsp_fetch_offset,
   output logic [CODE_W-1:0]   rsp_evicted_code
);

   localparam int IDX_W = $clog2(CACHE_ENTRIES);
   localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

   // slots fill in order and are never freed, so entries 0..count-1 are valid
   logic [CODE_W-1:0] mem [CACHE_ENTRIES];

   logic [GB_W-1:0]     gb_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CODE_W-1:0]   code_ff;
   logic                bad_ff;
   logic [LIN_W-1:0]    lin_ff;
   logic [OFF_W-1:0]    off_ff;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]    cmp_idx_ff;
   logic [CODE_W-1:0]   rd_data_ff;
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic                min_vld_ff, min_vld_in;
   logic [IDX_W-1:0]    min_idx_ff, min_idx_in;
   logic [CODE_W-1:0]   min_code_ff, min_code_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_in;
   logic [IDX_W-1:0]    slot_idx;
   logic [OFF_W-1:0]    off_out;
   logic [CODE_W-1:0]   evict_in;

   logic [BYTE_W-1:0]       row, col;
   logic                    bad_in;
   logic [LIN_W-1:0]        lin_in;
   logic [LIN_W+GB_W-1:0]   prod;
   logic                    issue;
   logic [IDX_W-1:0]        rd_addr;
   logic                    full;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   logic [IDX_W+SLOT_W-1:0] slot_wide;

   // input check and glyph index
   assign row    = req_char_code[BYTE_W-1:0];
   assign col    = req_char_code[CODE_W-1:BYTE_W];
   assign bad_in = (row < BYTE_LO) || (row > BYTE_HI) || (col < BYTE_LO) || (col > BYTE_HI);
   assign lin_in = LIN_W'(ROW_SPAN) * LIN_W'(row - BYTE_LO) + LIN_W'(col - BYTE_LO);
   assign prod   = lin_ff * gb_ff;

   // scan: one read issued per cycle, compared in the following cycle
   assign rd_addr = rd_idx_ff[IDX_W-1:0];
   assign issue   = cmd.scan && !bad_ff && !hit_ff && (rd_idx_ff != count_ff);
   assign full    = (count_ff == CNT_W'(CACHE_ENTRIES));

   assign sts.scan_done = bad_ff || hit_ff || ((rd_idx_ff == count_ff) && !rd_pend_ff);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rd_idx_in   = rd_idx_ff;
      rd_pend_in  = 1'b0;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      min_vld_in  = min_vld_ff;
      min_idx_in  = min_idx_ff;
      min_code_in = min_code_ff;
      if (cmd.load) begin
         rd_idx_in  = '0;
         hit_in     = 1'b0;
         min_vld_in = 1'b0;
      end else if (cmd.scan) begin
         if (issue) begin
            rd_idx_in  = rd_idx_ff + 1'b1;
            rd_pend_in = 1'b1;
         end
         if (rd_pend_ff && !hit_ff) begin
            if (rd_data_ff == code_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = cmp_idx_ff;
            end
            if (!min_vld_ff || (rd_data_ff < min_code_ff)) begin
               min_vld_in  = 1'b1;
               min_idx_in  = cmp_idx_ff;
               min_code_in = rd_data_ff;
            end
         end
      end
   end

   // final decision
   always_comb begin
      count_in  = count_ff;
      mem_we    = 1'b0;
      mem_waddr = count_ff[IDX_W-1:0];
      status_in = ST_INVALID;
      slot_idx  = '0;
      off_out   = '0;
      evict_in  = '0;
      if (bad_ff) begin
         status_in = ST_INVALID;
      end else if (hit_ff) begin
         status_in = ST_HIT;
         slot_idx  = hit_idx_ff;
      end else if (!full) begin
         status_in = ST_INSERT;
         slot_idx  = count_ff[IDX_W-1:0];
         off_out   = off_ff;
         mem_we    = cmd.finish;
         count_in  = cmd.finish ? count_ff + 1'b1 : count_ff;
      end else if (code_ff < min_code_ff) begin
         status_in = ST_NOT_KEPT;
         off_out   = off_ff;
      end else begin
         status_in = ST_EVICT;
         slot_idx  = min_idx_ff;
         off_out   = off_ff;
         evict_in  = min_code_ff;
         mem_we    = cmd.finish;
         mem_waddr = min_idx_ff;
      end
   end

   assign slot_wide = {{SLOT_W{1'b0}}, slot_idx};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gb_ff        <= GB_RESET;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         min_vld_ff   <= 1'b0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            gb_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rd_pend_ff   <= rd_pend_in;
         hit_ff       <= hit_in;
         min_vld_ff   <= min_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load) begin
            bad_ff <= bad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         code_ff <= req_char_code;
         lin_ff  <= lin_in;
      end
      off_ff      <= prod[OFF_W-1:0];
      cmp_idx_ff  <= rd_addr;
      hit_idx_ff  <= hit_idx_in;
      min_idx_ff  <= min_idx_in;
      min_code_ff <= min_code_in;
      if (cmd.finish) begin
         rsp_status       <= status_in;
         rsp_slot         <= slot_wide[SLOT_W-1:0];
         rsp_fetch_offset <= off_out;
         rsp_evicted_code <= evict_in;
      end
   end

   // code store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= code_ff;
      end
      if (issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/core/glyph_cache_min_evict.sv
// ----------------------------------------------------------------------------
// glyph_cache_min_evict
// Cache of two-byte GB2312 codes with glyph offset lookup and minimum-code
// eviction.
// ----------------------------------------------------------------------------
// One word is handled at a time. A word with a row or column byte outside
// A1..FE skips the scan. Otherwise the cached codes are read one per cycle
// from a single-port code store and checked for a match and for the smallest
// code; the scan covers every cached code (at most CACHE_ENTRIES), and a hit
// ends the scan early. A new word is taken in the cycle after each result is
// loaded. The next word can be accepted while the previous result still waits
// in the output register. The glyph offset multiply runs during the scan. No
// clearing pass is needed after reset.
module glyph_cache_min_evict import gcme_pkg::*; #(
   parameter int CACHE_ENTRIES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CODE_W-1:0]   req_char_code,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [OFF_W-1:0]    rsp_fetch_offset,
   output logic [CODE_W-1:0]   rsp_evicted_code,
   input  logic                csr_wr_en,
   input  logic [GB_W-1:0]     csr_wr_data
);

   gcme_cmd_type cmd;
   gcme_sts_type sts;

   gcme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gcme_dp #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_char_code    (req_char_code),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_fetch_offset (rsp_fetch_offset),
      .rsp_evicted_code (rsp_evicted_code)
   );

   // at most one command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan, cmd.finish}))
      else $error("more than one datapath command");

   // a finished result never overwrites one still waiting
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten");

   // one word in flight: busy right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a word while busy");

   // an invalid code carries no slot, offset or evicted code
   a_invalid_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_INVALID)) |->
         ((rsp_slot == '0) && (rsp_fetch_offset == '0) && (rsp_evicted_code == '0)))
      else $error("invalid result with nonzero fields");

endmodule
